// File: design/mwa_pkg.sv
// Shared constants, widths and state types for the moving window average block.
// No dependencies; every other file refers to it by scoped names.
package mwa_pkg;

  localparam int MAX_WINDOW_DEF   = 64;
  localparam int SAMPLE_WIDTH_DEF = 16;

  localparam int LEN_W       = 7;
  localparam int SUM_OUT_W   = 22;
  localparam int AVG_OUT_W   = 16;
  localparam int CFG_DATA_W  = 32;
  localparam int CFG_ADDR_W  = 3;
  localparam int QUEUE_DEPTH = 2;

  localparam logic [LEN_W-1:0] LEN_RESET = 7'd64;

  // Register index, taken from the word address bits of paddr
  localparam logic [CFG_ADDR_W-3:0] REG_WINDOW_LENGTH = '0;

  typedef enum logic {
    FR_IDLE,
    FR_UPDATE
  } front_state_t;

  typedef enum logic [1:0] {
    DV_IDLE,
    DV_RUN,
    DV_DONE
  } div_state_t;

  function automatic int pos_width(input int max_window);
    return (max_window > 1) ? $clog2(max_window) : 1;
  endfunction

  function automatic int sum_width(input int max_window, input int sample_width);
    return sample_width + pos_width(max_window);
  endfunction

endpackage

// File: design/mwa_front.sv
// Front end: sample ring memory, write position, filled flag and running sum.
// Pushes {running sum, divisor count} into the hand-off queue. Uses mwa_pkg.
module mwa_front #(
  parameter int MAX_WINDOW   = mwa_pkg::MAX_WINDOW_DEF,
  parameter int SAMPLE_WIDTH = mwa_pkg::SAMPLE_WIDTH_DEF
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   clear,
  input  logic [mwa_pkg::LEN_W-1:0]              len_cfg,
  input  logic                                   push,
  input  logic signed [SAMPLE_WIDTH-1:0]         in_sample,
  output logic                                   full,
  input  logic                                   q_full,
  output logic                                   q_push,
  output logic [mwa_pkg::sum_width(MAX_WINDOW, SAMPLE_WIDTH)+mwa_pkg::LEN_W-1:0] q_data
);

  localparam int PW    = mwa_pkg::pos_width(MAX_WINDOW);
  localparam int SUM_W = mwa_pkg::sum_width(MAX_WINDOW, SAMPLE_WIDTH);
  localparam int CW    = mwa_pkg::LEN_W;
  localparam int CMP_W = ((PW > CW) ? PW : CW) + 1;

  mwa_pkg::front_state_t state_r, state_nxt;

  logic signed [SAMPLE_WIDTH-1:0] ring_mem [MAX_WINDOW];
  logic signed [SAMPLE_WIDTH-1:0] rd_r;
  logic signed [SAMPLE_WIDTH-1:0] sample_r;
  logic signed [SUM_W-1:0]        sum_r, sum_nxt, old_ext, smp_ext;
  logic [PW-1:0]                  pos_r, pos_nxt, pos_eff;
  logic                           filled_r, filled_nxt;
  logic [CW-1:0]                  len, count_nxt;
  logic [CMP_W-1:0]               pos_inc;
  logic                           wrap, accept;

  // Saturate the configured length into 1..MAX_WINDOW
  always_comb begin
    if (len_cfg == '0) begin
      len = CW'(1);
    end else if (32'(len_cfg) > MAX_WINDOW) begin
      len = CW'(MAX_WINDOW);
    end else begin
      len = len_cfg;
    end
  end

  assign pos_eff = (CMP_W'(pos_r) >= CMP_W'(len)) ? '0 : pos_r;
  assign pos_inc = CMP_W'(pos_eff) + CMP_W'(1);
  assign wrap    = pos_inc >= CMP_W'(len);
  assign pos_nxt = wrap ? '0 : PW'(pos_inc);
  assign filled_nxt = filled_r | wrap;
  assign count_nxt  = filled_nxt ? len : CW'(pos_inc);

  // Entries are only trusted once the ring has wrapped; before that they read as zero
  assign old_ext = filled_r ? SUM_W'(rd_r) : '0;
  assign smp_ext = SUM_W'(sample_r);
  assign sum_nxt = sum_r - old_ext + smp_ext;

  assign q_data = {sum_nxt, count_nxt};

  always_comb begin
    state_nxt = state_r;
    accept    = 1'b0;
    q_push    = 1'b0;
    full      = 1'b1;
    case (state_r)
      mwa_pkg::FR_IDLE: begin
        full   = q_full;
        accept = push && !q_full;
        if (accept) begin
          state_nxt = mwa_pkg::FR_UPDATE;
        end
      end
      mwa_pkg::FR_UPDATE: begin
        q_push    = 1'b1;
        state_nxt = mwa_pkg::FR_IDLE;
      end
      default: begin
        state_nxt = mwa_pkg::FR_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= mwa_pkg::FR_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || clear) begin
      sum_r    <= '0;
      pos_r    <= '0;
      filled_r <= 1'b0;
    end else if (q_push) begin
      sum_r    <= sum_nxt;
      pos_r    <= pos_nxt;
      filled_r <= filled_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      sample_r <= in_sample;
    end
  end

  // Read every cycle at the current position; write back during the update cycle
  always_ff @(posedge clk) begin
    if (q_push) begin
      ring_mem[pos_eff] <= sample_r;
    end
    rd_r <= ring_mem[pos_eff];
  end

  a_clear_resets_window: assert property (@(posedge clk) disable iff (!rst_n)
    clear |=> (pos_r == '0) && !filled_r && (sum_r == '0))
    else $error("window state not cleared after length write");

  a_count_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    q_push |-> (count_nxt != '0) && (count_nxt <= len))
    else $error("divisor count outside 1..length");

endmodule

// File: design/mwa_queue.sv
// Short hand-off queue between the front end and the divider.
// Depth from mwa_pkg::QUEUE_DEPTH; payload width set by the instantiating module.
module mwa_queue #(
  parameter int WIDTH = 29
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  output logic             full,
  input  logic             pop,
  output logic             empty,
  output logic [WIDTH-1:0] pop_data
);

  localparam int DEPTH = mwa_pkg::QUEUE_DEPTH;
  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] slot_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0] cnt_r;
  logic             do_push, do_pop;

  assign full     = cnt_r == CNT_W'(DEPTH);
  assign empty    = cnt_r == '0;
  assign do_push  = push && !full;
  assign do_pop   = pop && !empty;
  assign pop_data = slot_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (32'(wr_ptr_r) == DEPTH - 1) ? '0 : wr_ptr_r + PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr_r <= (32'(rd_ptr_r) == DEPTH - 1) ? '0 : rd_ptr_r + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
        cnt_r <= cnt_r + CNT_W'(1);
      end else if (do_pop && !do_push) begin
        cnt_r <= cnt_r - CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

// File: design/mwa_divider.sv
// Back end: restoring signed divider, one quotient bit a cycle, and the result register.
// Takes {sum, count} requests from mwa_queue; uses mwa_pkg.
module mwa_divider #(
  parameter int SUM_W = 22
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 q_empty,
  input  logic [SUM_W+mwa_pkg::LEN_W-1:0]      q_data,
  output logic                                 q_pop,
  output logic                                 empty,
  input  logic                                 pop,
  output logic signed [mwa_pkg::SUM_OUT_W-1:0] out_window_sum,
  output logic signed [mwa_pkg::AVG_OUT_W-1:0] out_window_average
);

  localparam int CW     = mwa_pkg::LEN_W;
  localparam int STEP_W = $clog2(SUM_W);

  mwa_pkg::div_state_t state_r, state_nxt;

  logic signed [SUM_W-1:0] sum_in, sum_hold_r, quot;
  logic [SUM_W-1:0]        mag, dq_r;
  logic [CW-1:0]           div_r, rem_r;
  logic [CW:0]             rem_t;
  logic                    neg_r, ge, last, load_out;
  logic [STEP_W-1:0]       step_r;
  logic                    out_valid_r;

  assign sum_in = signed'(q_data[SUM_W+CW-1:CW]);
  assign mag    = sum_in[SUM_W-1] ? SUM_W'(-sum_in) : SUM_W'(sum_in);
  assign rem_t  = {rem_r, dq_r[SUM_W-1]};
  assign ge     = rem_t >= {1'b0, div_r};
  assign last   = step_r == STEP_W'(SUM_W - 1);
  assign quot   = neg_r ? SUM_W'(-dq_r) : SUM_W'(dq_r);
  assign empty  = !out_valid_r;

  always_comb begin
    state_nxt = state_r;
    q_pop     = 1'b0;
    load_out  = 1'b0;
    case (state_r)
      mwa_pkg::DV_IDLE: begin
        if (!q_empty) begin
          q_pop     = 1'b1;
          state_nxt = mwa_pkg::DV_RUN;
        end
      end
      mwa_pkg::DV_RUN: begin
        if (last) begin
          state_nxt = mwa_pkg::DV_DONE;
        end
      end
      mwa_pkg::DV_DONE: begin
        // Hold the quotient until the result register is free
        if (!out_valid_r || pop) begin
          load_out  = 1'b1;
          state_nxt = mwa_pkg::DV_IDLE;
        end
      end
      default: begin
        state_nxt = mwa_pkg::DV_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= mwa_pkg::DV_IDLE;
      out_valid_r <= 1'b0;
      step_r      <= '0;
    end else begin
      state_r <= state_nxt;
      if (load_out) begin
        out_valid_r <= 1'b1;
      end else if (pop) begin
        out_valid_r <= 1'b0;
      end
      if (q_pop) begin
        step_r <= '0;
      end else if (state_r == mwa_pkg::DV_RUN) begin
        step_r <= step_r + STEP_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      dq_r       <= mag;
      rem_r      <= '0;
      div_r      <= q_data[CW-1:0];
      neg_r      <= sum_in[SUM_W-1];
      sum_hold_r <= sum_in;
    end else if (state_r == mwa_pkg::DV_RUN) begin
      rem_r <= ge ? CW'(rem_t - {1'b0, div_r}) : rem_t[CW-1:0];
      dq_r  <= {dq_r[SUM_W-2:0], ge};
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_window_sum     <= mwa_pkg::SUM_OUT_W'(sum_hold_r);
      out_window_average <= mwa_pkg::AVG_OUT_W'(quot);
    end
  end

  a_pop_needs_request: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> !q_empty)
    else $error("divider took from an empty queue");

  a_rem_below_divisor: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == mwa_pkg::DV_RUN) |-> (rem_r < div_r))
    else $error("partial remainder not below divisor");

  a_done_fills_output: assert property (@(posedge clk) disable iff (!rst_n)
    load_out |=> out_valid_r && (state_r == mwa_pkg::DV_IDLE))
    else $error("finished quotient not delivered to result register");

endmodule

// File: design/moving_window_average.sv
// Moving window average: ring of recent samples, running sum and truncating average.
// Throughput is set by the divider, which resolves one quotient bit a cycle while running and
//   finishes one request before it takes the next; the front end takes a new sample only
//   after the update state of the last one, and the hand-off queue buffers between the two.
// Reset (rst_n low, synchronous) empties the hand-off queue, sets window_length to 64 and
//   clears the window; a window_length write clears it again. No clearing pass is needed.
module moving_window_average #(
  parameter int MAX_WINDOW   = mwa_pkg::MAX_WINDOW_DEF,
  parameter int SAMPLE_WIDTH = mwa_pkg::SAMPLE_WIDTH_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 push,
  output logic                                 full,
  input  logic signed [SAMPLE_WIDTH-1:0]       in_sample,
  output logic                                 empty,
  input  logic                                 pop,
  output logic signed [mwa_pkg::SUM_OUT_W-1:0] out_window_sum,
  output logic signed [mwa_pkg::AVG_OUT_W-1:0] out_window_average,
  input  logic                                 psel,
  input  logic                                 penable,
  input  logic                                 pwrite,
  input  logic [mwa_pkg::CFG_ADDR_W-1:0]       paddr,
  input  logic [mwa_pkg::CFG_DATA_W-1:0]       pwdata,
  output logic [mwa_pkg::CFG_DATA_W-1:0]       prdata,
  output logic                                 pready
);

  localparam int SUM_W = mwa_pkg::sum_width(MAX_WINDOW, SAMPLE_WIDTH);
  localparam int QW    = SUM_W + mwa_pkg::LEN_W;

  logic [mwa_pkg::LEN_W-1:0] len_r;
  logic                      reg_hit, cfg_we;
  logic                      q_push, q_full, q_pop, q_empty;
  logic [QW-1:0]             q_wdata, q_rdata;

  assign pready  = 1'b1;
  assign reg_hit = paddr[mwa_pkg::CFG_ADDR_W-1:2] == mwa_pkg::REG_WINDOW_LENGTH;
  assign cfg_we  = psel && penable && pwrite && pready && reg_hit;
  assign prdata  = reg_hit ? mwa_pkg::CFG_DATA_W'(len_r) : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_r <= mwa_pkg::LEN_RESET;
    end else if (cfg_we) begin
      len_r <= pwdata[mwa_pkg::LEN_W-1:0];
    end
  end

  mwa_front #(
    .MAX_WINDOW   (MAX_WINDOW),
    .SAMPLE_WIDTH (SAMPLE_WIDTH)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .clear     (cfg_we),
    .len_cfg   (len_r),
    .push      (push),
    .in_sample (in_sample),
    .full      (full),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_data    (q_wdata)
  );

  mwa_queue #(
    .WIDTH (QW)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_wdata),
    .full      (q_full),
    .pop       (q_pop),
    .empty     (q_empty),
    .pop_data  (q_rdata)
  );

  mwa_divider #(
    .SUM_W (SUM_W)
  ) u_divider (
    .clk                (clk),
    .rst_n              (rst_n),
    .q_empty            (q_empty),
    .q_data             (q_rdata),
    .q_pop              (q_pop),
    .empty              (empty),
    .pop                (pop),
    .out_window_sum     (out_window_sum),
    .out_window_average (out_window_average)
  );

endmodule

// File: verif/moving_window_average_tb.sv
`timescale 1ns / 100ps
// Testbench for moving_window_average: directed and random samples checked against
// an in-bench window predictor, with window length changes over the APB-style port.
// Depends on mwa_pkg and the moving_window_average RTL.
module moving_window_average_tb;

  localparam int SW            = mwa_pkg::SAMPLE_WIDTH_DEF;
  localparam int SETTLE_CYCLES = 40;
  localparam int RANDOM_ITEMS  = 1130;
  localparam int PRINT_LIMIT   = 40;

  typedef logic signed [SW-1:0] sample_t;
  typedef struct packed {
    logic signed [mwa_pkg::SUM_OUT_W-1:0] window_sum;
    logic signed [mwa_pkg::AVG_OUT_W-1:0] window_average;
  } window_result_t;

  logic                                 clk;
  logic                                 rst_n;
  logic                                 push;
  logic                                 full;
  sample_t                              in_sample;
  logic                                 empty;
  logic                                 pop = 1'b0;
  logic signed [mwa_pkg::SUM_OUT_W-1:0] out_window_sum;
  logic signed [mwa_pkg::AVG_OUT_W-1:0] out_window_average;
  logic                                 psel;
  logic                                 penable;
  logic                                 pwrite;
  logic [mwa_pkg::CFG_ADDR_W-1:0]       paddr;
  logic [mwa_pkg::CFG_DATA_W-1:0]       pwdata;
  logic [mwa_pkg::CFG_DATA_W-1:0]       prdata;
  logic                                 pready;

  // Predictor state
  sample_t                   ring_copy [mwa_pkg::MAX_WINDOW_DEF];
  int                        ring_index;
  bit                        ring_filled;
  longint                    ring_total;
  logic [mwa_pkg::LEN_W-1:0] length_reg;

  window_result_t pending_averages[$];
  int             error_count;
  int             burst_left;
  int             sent_random;
  logic [31:0]    stall_pattern = '1;
  logic [7:0]     stall_phase = '0;

  moving_window_average dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .push               (push),
    .full               (full),
    .in_sample          (in_sample),
    .empty              (empty),
    .pop                (pop),
    .out_window_sum     (out_window_sum),
    .out_window_average (out_window_average),
    .psel               (psel),
    .penable            (penable),
    .pwrite             (pwrite),
    .paddr              (paddr),
    .pwdata             (pwdata),
    .prdata             (prdata),
    .pready             (pready)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    #8_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

  function automatic void clear_window_copy();
    for (int i = 0; i < mwa_pkg::MAX_WINDOW_DEF; i++) ring_copy[i] = '0;
    ring_index  = 0;
    ring_filled = 1'b0;
    ring_total  = 0;
  endfunction

  function automatic window_result_t advance_window(input sample_t s);
    int             len;
    int             idx;
    longint         count;
    longint         quotient;
    window_result_t r;
    len = int'(length_reg);
    if (len < 1) len = 1;
    if (len > mwa_pkg::MAX_WINDOW_DEF) len = mwa_pkg::MAX_WINDOW_DEF;
    idx = ring_index;
    if (idx >= len) idx = 0;
    ring_total = ring_total - ring_copy[idx] + s;
    ring_copy[idx] = s;
    idx++;
    if (idx >= len) begin
      idx = 0;
      ring_filled = 1'b1;
    end
    ring_index = idx;
    count = longint'(ring_filled ? len : idx);
    // Signed division truncates toward zero
    quotient = ring_total / count;
    r.window_sum     = ring_total[mwa_pkg::SUM_OUT_W-1:0];
    r.window_average = quotient[mwa_pkg::AVG_OUT_W-1:0];
    return r;
  endfunction

  task automatic flag_mismatch(input string what, input longint expected, input longint got);
    if (error_count < PRINT_LIMIT)
      $display("mismatch %s: expected %0d got %0d at %0t", what, expected, got, $realtime);
    error_count++;
  endtask

  // Result side: stall on a pattern refreshed each time the 8-bit phase counter wraps
  always @(posedge clk) begin
    stall_phase <= stall_phase + 8'd1;
    if (stall_phase == 8'd0) begin
      case ($urandom_range(0, 4))
        0, 1:    stall_pattern <= '1;
        2:       stall_pattern <= 32'h0000_0001;
        default: stall_pattern <= $urandom;
      endcase
    end
    pop <= stall_pattern[stall_phase[4:0]];
  end

  always @(posedge clk) begin : check_results
    window_result_t want;
    if (rst_n && pop && !empty) begin
      if (pending_averages.size() == 0) begin
        flag_mismatch("result with no request", 0, out_window_sum);
      end else begin
        want = pending_averages.pop_front();
        if (out_window_sum !== want.window_sum)
          flag_mismatch("window_sum", want.window_sum, out_window_sum);
        if (out_window_average !== want.window_average)
          flag_mismatch("window_average", want.window_average, out_window_average);
      end
    end
  end

  // Hold push high across back-to-back requests; drop it only for a gap
  task automatic push_sample(input sample_t s);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 30);
      if (gap != 0) begin
        push <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 16);
    end
    push      <= 1'b1;
    in_sample <= s;
    @(posedge clk);
    while (full) @(posedge clk);
    pending_averages.push_back(advance_window(s));
    burst_left--;
  endtask

  task automatic drain_results();
    push <= 1'b0;
    burst_left = 0;
    while (pending_averages.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic cfg_transfer(input bit is_write, input logic [mwa_pkg::CFG_DATA_W-1:0] word,
                              output logic [mwa_pkg::CFG_DATA_W-1:0] rdata);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= is_write;
    paddr   <= {mwa_pkg::REG_WINDOW_LENGTH, 2'b00};
    pwdata  <= word;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    rdata = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_window_length(input logic [mwa_pkg::CFG_DATA_W-1:0] word);
    logic [mwa_pkg::CFG_DATA_W-1:0] rd;
    drain_results();
    cfg_transfer(1'b1, word, rd);
    length_reg = word[mwa_pkg::LEN_W-1:0];
    clear_window_copy();
    cfg_transfer(1'b0, '0, rd);
    if (rd !== mwa_pkg::CFG_DATA_W'(word[mwa_pkg::LEN_W-1:0]))
      flag_mismatch("window_length readback", word[mwa_pkg::LEN_W-1:0], rd);
  endtask

  task automatic test_reset_state();
    logic [mwa_pkg::CFG_DATA_W-1:0] rd;
    cfg_transfer(1'b0, '0, rd);
    if (rd !== mwa_pkg::CFG_DATA_W'(mwa_pkg::LEN_RESET))
      flag_mismatch("window_length after reset", mwa_pkg::LEN_RESET, rd);
  endtask

  task automatic test_extreme_samples();
    push_sample(16'sh7FFF);
    push_sample(16'sh8000);
    push_sample(16'sh0000);
    push_sample(16'shFFFF);
    push_sample(16'sh0001);
    push_sample(16'sh5555);
    push_sample(16'shAAAA);
  endtask

  // Zero saturates up to one sample; anything above the maximum saturates down
  task automatic test_length_saturation();
    set_window_length(32'd0);
    push_sample(16'sh8000);
    push_sample(16'sh7FFF);
    push_sample(-16'sd7);
    set_window_length(32'd65);
    push_sample(16'sh7FFF);
    push_sample(16'sh7FFF);
    set_window_length(32'd127);
    push_sample(16'sh8000);
    push_sample(16'sh0003);
  endtask

  // Partial fill divides by the samples seen; check wrap and truncation
  task automatic test_partial_fill();
    set_window_length(32'hFFFF_FF83);
    push_sample(16'sd5);
    push_sample(-16'sd3);
    push_sample(-16'sd8);
    push_sample(16'sd7);
    set_window_length(32'd2);
    push_sample(-16'sd1);
    push_sample(16'sd0);
    push_sample(-16'sd1);
    push_sample(16'sd1);
  endtask

  task automatic test_random_windows();
    int                             style;
    int                             phase_len;
    bit                             neg;
    logic [mwa_pkg::CFG_DATA_W-1:0] word;
    sample_t                        s;
    while (sent_random < RANDOM_ITEMS) begin
      case ($urandom_range(0, 7))
        0:       word = 32'd1;
        1:       word = 32'd64;
        2:       word = 32'd0;
        3:       word = $urandom_range(65, 127);
        4:       word = $urandom_range(2, 8);
        default: word = $urandom_range(1, 64);
      endcase
      if ($urandom_range(0, 3) == 0)
        word[mwa_pkg::CFG_DATA_W-1:mwa_pkg::LEN_W] =
          (mwa_pkg::CFG_DATA_W - mwa_pkg::LEN_W)'($urandom);
      set_window_length(word);
      style     = $urandom_range(0, 3);
      neg       = 1'($urandom_range(0, 1));
      phase_len = $urandom_range(20, 120);
      for (int k = 0; k < phase_len; k++) begin
        case (style)
          // Sustained extremes drive the sum to its limits
          1:       s = neg ? 16'sh8000 : 16'sh7FFF;
          2:       s = sample_t'(int'($urandom_range(0, 16)) - 8);
          default: s = sample_t'($urandom);
        endcase
        push_sample(s);
        if (k == phase_len / 2 && $urandom_range(0, 5) == 0) drain_results();
      end
      sent_random += phase_len;
    end
  endtask

  initial begin
    push      <= 1'b0;
    in_sample <= '0;
    psel      <= 1'b0;
    penable   <= 1'b0;
    pwrite    <= 1'b0;
    paddr     <= '0;
    pwdata    <= '0;
    rst_n     <= 1'b0;
    error_count = 0;
    burst_left  = 0;
    sent_random = 0;
    length_reg  = mwa_pkg::LEN_RESET;
    clear_window_copy();
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_reset_state();
    test_extreme_samples();
    test_length_saturation();
    test_partial_fill();
    test_random_windows();
    drain_results();

    if (error_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
